[design/pcab_pkg.sv]
// Shared constants, types and per-edge helper functions for the polygon contain/area/bounds block.
`timescale 1ns / 1ps
package pcab_pkg;

   localparam int COORD_BITS   = 16;
   localparam int MAX_VERTICES = 1024;

   localparam int COUNT_W = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W  = COORD_BITS + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SHOE_W  = 2 * COORD_BITS;
   localparam int TERM_W  = SHOE_W + 1;
   localparam int ACC_W   = 43;
   localparam int AREA_W  = 42;
   localparam int MIN_POLY_VERTICES = 3;

   // Operands of one edge, taken from the previous vertex (b) to the current one (a).
   typedef struct packed {
      logic                         active;
      logic                         straddle;
      logic signed [DIFF_W-1:0]     dy;
      logic signed [DIFF_W-1:0]     dqx;
      logic signed [DIFF_W-1:0]     dxb;
      logic signed [DIFF_W-1:0]     dqy;
      logic signed [COORD_BITS-1:0] xa;
      logic signed [COORD_BITS-1:0] ya;
      logic signed [COORD_BITS-1:0] xb;
      logic signed [COORD_BITS-1:0] yb;
   } edge_ops_type;

   typedef struct packed {
      logic                     active;
      logic                     straddle;
      logic                     dy_pos;
      logic signed [PROD_W-1:0] lhs;
      logic signed [PROD_W-1:0] rhs;
      logic signed [SHOE_W-1:0] p;
      logic signed [SHOE_W-1:0] q;
   } edge_prod_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] max_y;
      logic [COUNT_W-1:0]           total;
      logic                         enough;
      logic                         overflow;
   } poly_info_type;

   function automatic logic signed [DIFF_W-1:0] sub_ext(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [DIFF_W-1:0] r;
      r = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      return r;
   endfunction

   function automatic edge_ops_type make_edge(
      input logic                         active,
      input logic signed [COORD_BITS-1:0] xa,
      input logic signed [COORD_BITS-1:0] ya,
      input logic signed [COORD_BITS-1:0] xb,
      input logic signed [COORD_BITS-1:0] yb,
      input logic signed [COORD_BITS-1:0] qx,
      input logic signed [COORD_BITS-1:0] qy
   );
      edge_ops_type e;
      e.active   = active;
      // half-open rule: a vertex on the query line counts as below
      e.straddle = active & (($signed(ya) > $signed(qy)) ^ ($signed(yb) > $signed(qy)));
      e.dy       = sub_ext(yb, ya);
      e.dqx      = sub_ext(qx, xa);
      e.dxb      = sub_ext(xb, xa);
      e.dqy      = sub_ext(qy, ya);
      e.xa       = xa;
      e.ya       = ya;
      e.xb       = xb;
      e.yb       = yb;
      return e;
   endfunction

   function automatic edge_prod_type make_prod(input edge_ops_type e);
      edge_prod_type r;
      r.active   = e.active;
      r.straddle = e.straddle;
      r.dy_pos   = ~e.dy[DIFF_W-1];
      r.lhs      = $signed(e.dqx) * $signed(e.dy);
      r.rhs      = $signed(e.dxb) * $signed(e.dqy);
      r.p        = $signed(e.xb) * $signed(e.ya);
      r.q        = $signed(e.xa) * $signed(e.yb);
      return r;
   endfunction

   // Exact form of qx < xa + (xb-xa)*(qy-ya)/dy; the sense flips with the sign of dy.
   function automatic logic edge_cross(input edge_prod_type r);
      logic lt;
      logic gt;
      lt = $signed(r.lhs) < $signed(r.rhs);
      gt = $signed(r.lhs) > $signed(r.rhs);
      return r.straddle & (r.dy_pos ? lt : gt);
   endfunction

   function automatic logic signed [TERM_W-1:0] edge_term(input edge_prod_type r);
      logic signed [TERM_W-1:0] t;
      if (r.active) begin
         t = $signed({r.p[SHOE_W-1], r.p}) - $signed({r.q[SHOE_W-1], r.q});
      end else begin
         t = '0;
      end
      return t;
   endfunction

endpackage

[design/polygon_contain_area_bounds.sv]
// Streaming point-in-polygon test with shoelace area, bounding box and vertex count.
//
// Usage: a polygon arrives on the req_ channel one vertex per request; the request
// that opens a polygon also carries the query point, which later requests ignore.
// The request with req_last_vertex set closes the polygon back to its first vertex
// and produces one response on the rsp_ channel: even-odd inside flag, twice the
// absolute area, bounding box, saturating vertex count and status flags. Polygons
// with fewer than three vertices report inside 0 and area 0.
// Throughput: one vertex per cycle, back to back and across polygon boundaries.
// Pipeline: the closing request passes five pipeline registers, the first loaded at
// the accepting edge: operand capture, edge multiplies, compare and term subtract,
// accumulate, and the area magnitude in the response register.
// Stall: a held response keeps the output register; the accumulate stage keeps one
// more finished polygon, and only when both are full does req_ready drop.
// Reset: synchronous, active high; clears the vertex count, the accumulator and
// all valid flags, so the next request opens a new polygon.
`timescale 1ns / 1ps
module polygon_contain_area_bounds (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [pcab_pkg::COORD_BITS-1:0] req_vertex_x,
   input  logic signed [pcab_pkg::COORD_BITS-1:0] req_vertex_y,
   input  logic signed [pcab_pkg::COORD_BITS-1:0] req_query_x,
   input  logic signed [pcab_pkg::COORD_BITS-1:0] req_query_y,
   input  logic                                   req_last_vertex,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_inside_res,
   output logic [pcab_pkg::AREA_W-1:0]            rsp_twice_area,
   output logic signed [pcab_pkg::COORD_BITS-1:0] rsp_box_min_x,
   output logic signed [pcab_pkg::COORD_BITS-1:0] rsp_box_max_x,
   output logic signed [pcab_pkg::COORD_BITS-1:0] rsp_box_min_y,
   output logic signed [pcab_pkg::COORD_BITS-1:0] rsp_box_max_y,
   output logic [pcab_pkg::COUNT_W-1:0]           rsp_vertex_total,
   output logic                                   rsp_enough_vertices,
   output logic                                   rsp_too_many
);
   import pcab_pkg::*;

   // front: per-polygon vertex state, updated at accept
   logic [COUNT_W-1:0]           cnt_ff, cnt_in;
   logic                         ovf_ff, ovf_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_BITS-1:0] held_qx_ff, held_qy_ff;
   logic signed [COORD_BITS-1:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [COORD_BITS-1:0] qx_use, qy_use, fx_use, fy_use;
   logic                         start, accept, en;
   poly_info_type                info_in;
   edge_ops_type                 main_ops, close_ops;

   // pipeline stages
   logic           s1_valid_ff, s1_last_ff;
   edge_ops_type   s1_main_ff, s1_close_ff;
   poly_info_type  s1_info_ff;
   logic           s2_valid_ff, s2_last_ff;
   edge_prod_type  s2_main_ff, s2_close_ff;
   poly_info_type  s2_info_ff;
   logic           s3_valid_ff, s3_last_ff;
   logic           s3_cross_main_ff, s3_cross_close_ff;
   logic signed [TERM_W-1:0] s3_term_main_ff, s3_term_close_ff;
   poly_info_type  s3_info_ff;

   // accumulator and finished-polygon register
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             parity_ff, parity_in;
   logic             f_valid_ff;
   logic [ACC_W-1:0] f_sum_ff;
   logic             f_parity_ff;
   poly_info_type    f_info_ff;

   // response register
   logic             o_valid_ff;
   logic             o_free, o_load;
   logic [ACC_W-1:0] mag;
   logic             o_inside_ff;
   logic [AREA_W-1:0] o_area_ff;
   poly_info_type    o_info_ff;

   assign o_free    = ~o_valid_ff | rsp_ready;
   assign o_load    = f_valid_ff & o_free;
   assign en        = ~f_valid_ff | o_free;
   assign req_ready = en;
   assign accept    = req_valid & req_ready;

   always_comb begin
      start  = (cnt_ff == '0);
      qx_use = start ? req_query_x : held_qx_ff;
      qy_use = start ? req_query_y : held_qy_ff;
      fx_use = start ? req_vertex_x : first_x_ff;
      fy_use = start ? req_vertex_y : first_y_ff;

      main_ops  = make_edge(~start, req_vertex_x, req_vertex_y, prev_x_ff, prev_y_ff,
                            qx_use, qy_use);
      close_ops = make_edge(req_last_vertex, fx_use, fy_use, req_vertex_x, req_vertex_y,
                            qx_use, qy_use);

      if (start) begin
         info_in.min_x = req_vertex_x;
         info_in.max_x = req_vertex_x;
         info_in.min_y = req_vertex_y;
         info_in.max_y = req_vertex_y;
         cnt_in        = COUNT_W'(1);
         ovf_in        = 1'b0;
      end else begin
         info_in.min_x = ($signed(req_vertex_x) < $signed(min_x_ff)) ? req_vertex_x : min_x_ff;
         info_in.max_x = ($signed(req_vertex_x) > $signed(max_x_ff)) ? req_vertex_x : max_x_ff;
         info_in.min_y = ($signed(req_vertex_y) < $signed(min_y_ff)) ? req_vertex_y : min_y_ff;
         info_in.max_y = ($signed(req_vertex_y) > $signed(max_y_ff)) ? req_vertex_y : max_y_ff;
         if (cnt_ff >= COUNT_W'(MAX_VERTICES)) begin
            cnt_in = cnt_ff;
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + COUNT_W'(1);
            ovf_in = ovf_ff;
         end
      end
      info_in.total    = cnt_in;
      info_in.enough   = (cnt_in >= COUNT_W'(MIN_POLY_VERTICES));
      info_in.overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff <= req_last_vertex ? '0 : cnt_in;
         ovf_ff <= req_last_vertex ? 1'b0 : ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_qx_ff <= qx_use;
         held_qy_ff <= qy_use;
         first_x_ff <= fx_use;
         first_y_ff <= fy_use;
         prev_x_ff  <= req_vertex_x;
         prev_y_ff  <= req_vertex_y;
         min_x_ff   <= info_in.min_x;
         max_x_ff   <= info_in.max_x;
         min_y_ff   <= info_in.min_y;
         max_y_ff   <= info_in.max_y;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         f_valid_ff  <= 1'b0;
         acc_ff      <= '0;
         parity_ff   <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         f_valid_ff  <= s3_valid_ff & s3_last_ff;
         acc_ff      <= acc_in;
         parity_ff   <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff        <= req_last_vertex;
         s1_main_ff        <= main_ops;
         s1_close_ff       <= close_ops;
         s1_info_ff        <= info_in;
         s2_last_ff        <= s1_last_ff;
         s2_main_ff        <= make_prod(s1_main_ff);
         s2_close_ff       <= make_prod(s1_close_ff);
         s2_info_ff        <= s1_info_ff;
         s3_last_ff        <= s2_last_ff;
         s3_cross_main_ff  <= edge_cross(s2_main_ff);
         s3_cross_close_ff <= edge_cross(s2_close_ff);
         s3_term_main_ff   <= edge_term(s2_main_ff);
         s3_term_close_ff  <= edge_term(s2_close_ff);
         s3_info_ff        <= s2_info_ff;
         f_sum_ff          <= acc_ff
                              + {{(ACC_W-TERM_W){s3_term_main_ff[TERM_W-1]}}, s3_term_main_ff}
                              + {{(ACC_W-TERM_W){s3_term_close_ff[TERM_W-1]}}, s3_term_close_ff};
         f_parity_ff       <= parity_ff ^ s3_cross_main_ff ^ s3_cross_close_ff;
         f_info_ff         <= s3_info_ff;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      parity_in = parity_ff;
      if (s3_valid_ff) begin
         if (s3_last_ff) begin
            // polygon closed: its total moves to the finished register
            acc_in    = '0;
            parity_in = 1'b0;
         end else begin
            acc_in    = acc_ff
                        + {{(ACC_W-TERM_W){s3_term_main_ff[TERM_W-1]}}, s3_term_main_ff}
                        + {{(ACC_W-TERM_W){s3_term_close_ff[TERM_W-1]}}, s3_term_close_ff};
            parity_in = parity_ff ^ s3_cross_main_ff ^ s3_cross_close_ff;
         end
      end
   end

   assign mag = f_sum_ff[ACC_W-1] ? (~f_sum_ff + ACC_W'(1)) : f_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_load) begin
         o_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         o_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         o_inside_ff <= f_info_ff.enough & f_parity_ff;
         o_area_ff   <= f_info_ff.enough ? mag[AREA_W-1:0] : '0;
         o_info_ff   <= f_info_ff;
      end
   end

   assign rsp_valid           = o_valid_ff;
   assign rsp_inside_res      = o_inside_ff;
   assign rsp_twice_area      = o_area_ff;
   assign rsp_box_min_x       = o_info_ff.min_x;
   assign rsp_box_max_x       = o_info_ff.max_x;
   assign rsp_box_min_y       = o_info_ff.min_y;
   assign rsp_box_max_y       = o_info_ff.max_y;
   assign rsp_vertex_total    = o_info_ff.total;
   assign rsp_enough_vertices = o_info_ff.enough;
   assign rsp_too_many        = o_info_ff.overflow;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_W'(MAX_VERTICES))
      else $error("vertex count above maximum");

   a_close_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_vertex |=> cnt_ff == '0)
      else $error("closing request did not restart polygon");

   a_enough_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_enough_vertices == (rsp_vertex_total >= COUNT_W'(MIN_POLY_VERTICES)))
      else $error("enough flag disagrees with count");

   a_small_poly_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_enough_vertices |-> !rsp_inside_res && rsp_twice_area == '0)
      else $error("degenerate polygon reported inside or area");

   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_many |-> rsp_vertex_total == COUNT_W'(MAX_VERTICES))
      else $error("overflow without saturated count");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_box_min_x) <= $signed(rsp_box_max_x)
                    && $signed(rsp_box_min_y) <= $signed(rsp_box_max_y))
      else $error("bounding box inverted");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the polygon containment, area and bounds block.
`timescale 1ns / 1ps
module tb_top;
   import pcab_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic               in_poly;
      logic [AREA_W-1:0]  area;
      coord_type          min_x;
      coord_type          max_x;
      coord_type          min_y;
      coord_type          max_y;
      logic [COUNT_W-1:0] total;
      logic               enough;
      logic               too_many;
   } poly_summary_type;

   typedef struct packed {
      coord_type        vx;
      coord_type        vy;
      coord_type        qx;
      coord_type        qy;
      logic             last;
      logic             typed;
      poly_summary_type summary;
   } vertex_req_type;

   typedef enum int {SPAN_FULL, SPAN_TIGHT, SPAN_EDGE, SPAN_MID} coord_span_type;
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} stall_style_type;

   localparam coord_type C_MIN = coord_type'(-(1 << (COORD_BITS - 1)));
   localparam coord_type C_MAX = coord_type'((1 << (COORD_BITS - 1)) - 1);
   localparam int DIR_ROWS  = 24;
   localparam int DIR_TYPED = 5;
   localparam int ITEM_TARGET = 450;

   // vx, vy, qx, qy, last, index of typed summary (-1: use the predictor)
   int dir_tab [DIR_ROWS][6] = '{
      '{-32768,  32767,  32767, -32768, 1,  0},  // lone vertex, query at extremes
      '{ 32767, -32768,     -1,      0, 0, -1},  // two vertices spanning the full range
      '{-32768,  32767,      0,      0, 1,  1},
      '{     0,      0,      5,      5, 0, -1},  // square, query inside
      '{    10,      0,     -7,     -7, 0, -1},
      '{    10,     10,      0,      0, 0, -1},
      '{     0,     10,      0,      0, 1,  2},
      '{     0,      0,     15,      5, 0, -1},  // square, query outside
      '{    10,      0,      5,      5, 0, -1},
      '{    10,     10,      5,      5, 0, -1},
      '{     0,     10,      5,      5, 1,  3},
      '{     0,      0,      5,      5, 0, -1},  // clockwise square
      '{     0,     10,      0,      0, 0, -1},
      '{    10,     10,      0,      0, 0, -1},
      '{    10,      0,      0,      0, 1,  4},
      '{-32768, -32768,   -100,   -100, 0, -1},  // largest triangle
      '{ 32767, -32768,      0,      0, 0, -1},
      '{-32768,  32767,      0,      0, 1, -1},
      '{     0,      0,      2,      5, 0, -1},  // vertex on the query's horizontal line
      '{    10,      5,      0,      0, 0, -1},
      '{     0,     10,      0,      0, 1, -1},
      '{     3,      3,      3,      3, 0, -1},  // query sits on a vertex
      '{     9,      3,      0,      0, 0, -1},
      '{     3,      9,      0,      0, 1, -1}
   };

   // in_poly, area, min_x, max_x, min_y, max_y, total, enough, too_many
   longint typed_tab [DIR_TYPED][9] = '{
      '{0,   0, -32768, -32768, 32767, 32767, 1, 0, 0},
      '{0,   0, -32768,  32767, -32768, 32767, 2, 0, 0},
      '{1, 200,      0,     10,     0,    10, 4, 1, 0},
      '{0, 200,      0,     10,     0,    10, 4, 1, 0},
      '{1, 200,      0,     10,     0,    10, 4, 1, 0}
   };

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   coord_type          req_vertex_x    = '0;
   coord_type          req_vertex_y    = '0;
   coord_type          req_query_x     = '0;
   coord_type          req_query_y     = '0;
   logic               req_last_vertex = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic               rsp_inside_res;
   logic [AREA_W-1:0]  rsp_twice_area;
   coord_type          rsp_box_min_x;
   coord_type          rsp_box_max_x;
   coord_type          rsp_box_min_y;
   coord_type          rsp_box_max_y;
   logic [COUNT_W-1:0] rsp_vertex_total;
   logic               rsp_enough_vertices;
   logic               rsp_too_many;

   // typed expectation riding along with the request on the bus
   logic               cur_typed = 1'b0;
   poly_summary_type   cur_known = '0;

   vertex_req_type   vertex_stream [$];
   poly_summary_type expected_polys [$];

   // predictor state
   longint        first_x, first_y, prev_x, prev_y, hold_qx, hold_qy;
   longint        lo_x, hi_x, lo_y, hi_y;
   bit            parity;
   logic [42:0]   shoe_sum;
   int unsigned   n_seen = 0;
   bit            ovf;

   int unsigned      mismatches = 0;
   int unsigned      polys_checked = 0;
   int unsigned      polys_inside = 0;
   int unsigned      polys_thin = 0;
   int unsigned      polys_oversized = 0;
   int               burst_left = 0;
   bit               produced;
   poly_summary_type predicted;
   poly_summary_type want;

   polygon_contain_area_bounds dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // exact crossing test for the edge (xb,yb) -> (xa,ya)
   function automatic bit edge_hits(longint xa, longint ya, longint xb, longint yb);
      longint dy, lhs, rhs;
      if ((ya > hold_qy) == (yb > hold_qy)) return 1'b0;
      dy  = yb - ya;
      lhs = (hold_qx - xa) * dy;
      rhs = (xb - xa) * (hold_qy - ya);
      return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
   endfunction

   function automatic void walk_edge(longint xa, longint ya, longint xb, longint yb);
      longint p, q;
      p = xb * ya;
      q = xa * yb;
      parity   = parity ^ edge_hits(xa, ya, xb, yb);
      shoe_sum = shoe_sum + 43'(p - q);
   endfunction

   function automatic bit take_vertex(input coord_type vx16, input coord_type vy16,
                                      input coord_type qx16, input coord_type qy16,
                                      input logic last, output poly_summary_type s);
      longint      vx, vy;
      logic [42:0] mag;
      vx = vx16;
      vy = vy16;
      s  = '0;
      if (n_seen == 0) begin
         hold_qx  = qx16;
         hold_qy  = qy16;
         first_x  = vx;
         first_y  = vy;
         lo_x     = vx;
         hi_x     = vx;
         lo_y     = vy;
         hi_y     = vy;
         parity   = 1'b0;
         shoe_sum = '0;
         ovf      = 1'b0;
         n_seen   = 1;
      end else begin
         walk_edge(vx, vy, prev_x, prev_y);
         if (vx < lo_x) lo_x = vx;
         if (vx > hi_x) hi_x = vx;
         if (vy < lo_y) lo_y = vy;
         if (vy > hi_y) hi_y = vy;
         if (n_seen >= MAX_VERTICES) ovf = 1'b1;
         else n_seen++;
      end
      prev_x = vx;
      prev_y = vy;
      if (!last) return 1'b0;
      walk_edge(first_x, first_y, vx, vy);
      s.enough = (n_seen >= 3);
      if (s.enough) begin
         mag       = shoe_sum[42] ? -shoe_sum : shoe_sum;
         s.area    = mag[AREA_W-1:0];
         s.in_poly = parity;
      end
      s.min_x    = coord_type'(lo_x);
      s.max_x    = coord_type'(hi_x);
      s.min_y    = coord_type'(lo_y);
      s.max_y    = coord_type'(hi_y);
      s.total    = COUNT_W'(n_seen);
      s.too_many = ovf;
      n_seen     = 0;
      return 1'b1;
   endfunction

   function automatic coord_type pick_coord(coord_span_type span);
      case (span)
         SPAN_FULL:  return coord_type'($urandom);
         SPAN_TIGHT: return coord_type'(int'($urandom_range(0, 40)) - 20);
         SPAN_EDGE: begin
            case ($urandom_range(0, 5))
               0:       return C_MIN;
               1:       return coord_type'(C_MIN + 1);
               2:       return coord_type'(-1);
               3:       return coord_type'(0);
               4:       return coord_type'(C_MAX - 1);
               default: return C_MAX;
            endcase
         end
         default:    return coord_type'(int'($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   function automatic coord_span_type any_span();
      return coord_span_type'($urandom_range(0, 3));
   endfunction

   function automatic void add_vertex(coord_type vx, coord_type vy, coord_type qx,
                                      coord_type qy, logic last);
      vertex_req_type v;
      v      = '0;
      v.vx   = vx;
      v.vy   = vy;
      v.qx   = qx;
      v.qy   = qy;
      v.last = last;
      vertex_stream = {vertex_stream, v};
   endfunction

   task automatic add_random_polygon();
      int unsigned    pick, n;
      coord_span_type span;
      bit             mixed;
      coord_type      x0, x1, y0, y1, qx, qy;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         // axis-aligned rectangle with the query near its center
         x0 = pick_coord(SPAN_MID);
         x1 = pick_coord(SPAN_MID);
         y0 = pick_coord(SPAN_MID);
         y1 = pick_coord(SPAN_MID);
         qx = coord_type'((int'(x0) + int'(x1)) / 2 + int'($urandom_range(0, 2)) - 1);
         qy = coord_type'((int'(y0) + int'(y1)) / 2 + int'($urandom_range(0, 2)) - 1);
         if ($urandom_range(0, 1)) begin
            add_vertex(x0, y0, qx, qy, 1'b0);
            add_vertex(x1, y0, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL), 1'b0);
            add_vertex(x1, y1, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL), 1'b0);
            add_vertex(x0, y1, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL), 1'b1);
         end else begin
            add_vertex(x0, y1, qx, qy, 1'b0);
            add_vertex(x1, y1, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL), 1'b0);
            add_vertex(x1, y0, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL), 1'b0);
            add_vertex(x0, y0, pick_coord(SPAN_FULL), pick_coord(SPAN_FULL), 1'b1);
         end
      end else begin
         if (pick < 70) begin
            n     = $urandom_range(3, 10);
            span  = SPAN_TIGHT;
            mixed = 1'b0;
         end else if (pick < 85) begin
            n     = $urandom_range(3, 8);
            span  = SPAN_FULL;
            mixed = 1'b1;
         end else begin
            n     = $urandom_range(1, 2);
            span  = any_span();
            mixed = 1'b1;
         end
         qx = pick_coord(span);
         qy = pick_coord(span);
         for (int i = 0; i < n; i++) begin
            if (mixed) span = any_span();
            add_vertex(pick_coord(span), pick_coord(span),
                       (i == 0) ? qx : pick_coord(SPAN_FULL),
                       (i == 0) ? qy : pick_coord(SPAN_FULL), i == n - 1);
         end
      end
   endtask

   task automatic send_vertex(input vertex_req_type v);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_vertex_x    <= v.vx;
      req_vertex_y    <= v.vy;
      req_query_x     <= v.qx;
      req_query_y     <= v.qy;
      req_last_vertex <= v.last;
      cur_typed       <= v.typed;
      cur_known       <= v.summary;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic void compare_field(string field, longint exp_val, longint got_val);
      if (exp_val != got_val) begin
         $error("%s: expected %0d, got %0d", field, exp_val, got_val);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         produced = take_vertex(req_vertex_x, req_vertex_y, req_query_x, req_query_y,
                                req_last_vertex, predicted);
         if (produced) expected_polys = {expected_polys, (cur_typed ? cur_known : predicted)};
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_polys.size() == 0) begin
            $error("response with no request pending");
            mismatches++;
         end else begin
            want = expected_polys.pop_front();
            polys_checked++;
            if (want.in_poly) polys_inside++;
            if (!want.enough) polys_thin++;
            if (want.too_many) polys_oversized++;
            compare_field("inside_res", want.in_poly, rsp_inside_res);
            compare_field("twice_area", want.area, rsp_twice_area);
            compare_field("box_min_x", want.min_x, rsp_box_min_x);
            compare_field("box_max_x", want.max_x, rsp_box_max_x);
            compare_field("box_min_y", want.min_y, rsp_box_min_y);
            compare_field("box_max_y", want.max_y, rsp_box_max_y);
            compare_field("vertex_total", want.total, rsp_vertex_total);
            compare_field("enough_vertices", want.enough, rsp_enough_vertices);
            compare_field("too_many", want.too_many, rsp_too_many);
         end
      end
   end

   // response side: changing stall styles plus two long hold-offs to back up the pipe
   initial begin
      int unsigned     cyc, style_left, hold_left;
      stall_style_type style;
      cyc        = 0;
      style_left = 0;
      hold_left  = 0;
      style      = READY_ALWAYS;
      while (reset) @(posedge clock);
      forever begin
         if (cyc == 250 || cyc == 1800) hold_left = 150;
         if (style_left == 0) begin
            style      = stall_style_type'($urandom_range(0, 2));
            style_left = $urandom_range(10, 80);
         end
         style_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_COIN:   rsp_ready <= $urandom_range(0, 1);
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         cyc++;
         @(posedge clock);
      end
   end

   initial begin
      vertex_req_type v;
      for (int r = 0; r < DIR_ROWS; r++) begin
         v      = '0;
         v.vx   = coord_type'(dir_tab[r][0]);
         v.vy   = coord_type'(dir_tab[r][1]);
         v.qx   = coord_type'(dir_tab[r][2]);
         v.qy   = coord_type'(dir_tab[r][3]);
         v.last = dir_tab[r][4][0];
         if (dir_tab[r][5] >= 0) begin
            v.typed            = 1'b1;
            v.summary.in_poly  = typed_tab[dir_tab[r][5]][0][0];
            v.summary.area     = AREA_W'(typed_tab[dir_tab[r][5]][1]);
            v.summary.min_x    = coord_type'(typed_tab[dir_tab[r][5]][2]);
            v.summary.max_x    = coord_type'(typed_tab[dir_tab[r][5]][3]);
            v.summary.min_y    = coord_type'(typed_tab[dir_tab[r][5]][4]);
            v.summary.max_y    = coord_type'(typed_tab[dir_tab[r][5]][5]);
            v.summary.total    = COUNT_W'(typed_tab[dir_tab[r][5]][6]);
            v.summary.enough   = typed_tab[dir_tab[r][5]][7][0];
            v.summary.too_many = typed_tab[dir_tab[r][5]][8][0];
         end
         vertex_stream = {vertex_stream, v};
      end
      while (vertex_stream.size() < ITEM_TARGET) add_random_polygon();

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (vertex_stream[i]) send_vertex(vertex_stream[i]);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_polys.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d vertex requests; checked %0d polygons (%0d inside, %0d under three",
               vertex_stream.size(), polys_checked, polys_inside, polys_thin);
      $display("vertices, %0d over the vertex limit), %0d field mismatches",
               polys_oversized, mismatches);
      if (mismatches == 0 && expected_polys.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
